// ===== hdl/mx3i_pkg.sv =====
// Shared constants for the 3x3 matrix inverse unit.
// No dependencies; imported by the cofactor stage, the divider and the top level.
`default_nettype none

package mx3i_pkg;

   localparam int NUM_ELEMS = 9;

   typedef logic [3:0] elem_idx_type;

   // Adjugate entry k is e[i0]*e[i1] - e[i2]*e[i3], row-major element numbering.
   localparam elem_idx_type ADJ_IDX [NUM_ELEMS][4] = '{
      '{4'd4, 4'd8, 4'd5, 4'd7}, '{4'd2, 4'd7, 4'd1, 4'd8}, '{4'd1, 4'd5, 4'd2, 4'd4},
      '{4'd5, 4'd6, 4'd3, 4'd8}, '{4'd0, 4'd8, 4'd2, 4'd6}, '{4'd2, 4'd3, 4'd0, 4'd5},
      '{4'd3, 4'd7, 4'd4, 4'd6}, '{4'd1, 4'd6, 4'd0, 4'd7}, '{4'd0, 4'd4, 4'd1, 4'd3}
   };

endpackage

`default_nettype wire

// ===== hdl/mx3i_cofactor.sv =====
// Seven-stage pipeline forming the adjugate, the determinant and the rounded
// division operands. Depends on mx3i_pkg.
`default_nettype none

module mx3i_cofactor #(
   parameter int E  = 32,
   parameter int F  = 16,
   parameter int AW = 65,
   parameter int DW = 97,
   parameter int NW = 98
) (
   input  wire logic                 clock,
   input  wire logic                 en,
   input  wire logic signed [E-1:0]  elem [mx3i_pkg::NUM_ELEMS],
   output logic         [NW-1:0]     num [mx3i_pkg::NUM_ELEMS],
   output logic                      neg [mx3i_pkg::NUM_ELEMS],
   output logic         [DW-1:0]     twod,
   output logic                      det_zero
);
   import mx3i_pkg::*;

   // Stage 1: the eighteen element products.
   logic signed [2*E-1:0] p_ff [NUM_ELEMS];
   logic signed [2*E-1:0] q_ff [NUM_ELEMS];
   logic signed [E-1:0]   row_s1_ff [3];
   // Stage 2: adjugate entries.
   logic signed [AW-1:0]  adj_s2_ff [NUM_ELEMS];
   logic signed [E-1:0]   row_s2_ff [3];
   // Stage 3: split products for the determinant.
   logic signed [2*E:0]   ph_ff [3];
   logic signed [2*E:0]   pl_ff [3];
   logic signed [AW-1:0]  adj_s3_ff [NUM_ELEMS];
   // Stage 4: determinant terms.
   logic signed [DW-1:0]  term_ff [3];
   logic signed [AW-1:0]  adj_s4_ff [NUM_ELEMS];
   // Stage 5: determinant and adjugate magnitudes.
   logic signed [DW-1:0]  det_ff;
   logic        [AW-1:0]  mag_s5_ff [NUM_ELEMS];
   logic                  sgn_s5_ff [NUM_ELEMS];
   // Stage 6: determinant magnitude.
   logic        [DW-1:0]  absd_ff;
   logic                  dneg_ff;
   logic                  dz_s6_ff;
   logic        [AW-1:0]  mag_s6_ff [NUM_ELEMS];
   logic                  sgn_s6_ff [NUM_ELEMS];
   // Stage 7: division operands.
   logic        [NW-1:0]  num_ff [NUM_ELEMS];
   logic                  neg_ff [NUM_ELEMS];
   logic        [DW-1:0]  twod_ff;
   logic                  dz_ff;

   logic signed [DW-1:0]  det_in;
   logic        [DW-1:0]  absd_in;

   for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_adj
      logic        [AW-1:0] mag_in;
      logic        [NW-1:0] num_in;

      always_comb begin
         mag_in = adj_s4_ff[k][AW-1] ? AW'(-adj_s4_ff[k]) : AW'(adj_s4_ff[k]);
         // Adding |det| before halving by 2|det| rounds ties away from zero.
         num_in = (NW'(mag_s6_ff[k]) << (2*F+1)) + NW'(absd_ff);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            p_ff[k]      <= elem[ADJ_IDX[k][0]] * elem[ADJ_IDX[k][1]];
            q_ff[k]      <= elem[ADJ_IDX[k][2]] * elem[ADJ_IDX[k][3]];
            adj_s2_ff[k] <= AW'(p_ff[k]) - AW'(q_ff[k]);
            adj_s3_ff[k] <= adj_s2_ff[k];
            adj_s4_ff[k] <= adj_s3_ff[k];
            mag_s5_ff[k] <= mag_in;
            sgn_s5_ff[k] <= adj_s4_ff[k][AW-1];
            mag_s6_ff[k] <= mag_s5_ff[k];
            sgn_s6_ff[k] <= sgn_s5_ff[k];
            num_ff[k]    <= num_in;
            neg_ff[k]    <= sgn_s6_ff[k] ^ dneg_ff;
         end
      end

      assign num[k] = num_ff[k];
      assign neg[k] = neg_ff[k];
   end

   // Expansion along the first row: det = e0*adj0 + e1*adj3 + e2*adj6.
   for (genvar m = 0; m < 3; m++) begin : g_det
      logic signed [E:0]    hi_in;
      logic signed [E:0]    lo_in;
      logic signed [DW-1:0] term_in;

      always_comb begin
         hi_in   = adj_s2_ff[3*m][AW-1:E];
         lo_in   = $signed({1'b0, adj_s2_ff[3*m][E-1:0]});
         term_in = (DW'(ph_ff[m]) <<< E) + DW'(pl_ff[m]);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            row_s1_ff[m] <= elem[m];
            row_s2_ff[m] <= row_s1_ff[m];
            ph_ff[m]     <= row_s2_ff[m] * hi_in;
            pl_ff[m]     <= row_s2_ff[m] * lo_in;
            term_ff[m]   <= term_in;
         end
      end
   end

   always_comb begin
      det_in  = term_ff[0] + term_ff[1] + term_ff[2];
      absd_in = det_ff[DW-1] ? DW'(-det_ff) : DW'(det_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff   <= det_in;
         absd_ff  <= absd_in;
         dneg_ff  <= det_ff[DW-1];
         dz_s6_ff <= (det_ff == '0);
         twod_ff  <= absd_ff << 1;
         dz_ff    <= dz_s6_ff;
      end
   end

   assign twod     = twod_ff;
   assign det_zero = dz_ff;

endmodule

`default_nettype wire

// ===== hdl/mx3i_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sign,
// saturation and singular handling on the last stage. Depends on mx3i_pkg.
`default_nettype none

module mx3i_divider #(
   parameter int E  = 32,
   parameter int NW = 98,
   parameter int DW = 97,
   parameter int CW = 130
) (
   input  wire logic                clock,
   input  wire logic                en,
   input  wire logic [NW-1:0]       num,
   input  wire logic [DW-1:0]       twod,
   input  wire logic                neg,
   input  wire logic                det_zero,
   output logic signed [E-1:0]      quot,
   output logic                     sat
);
   import mx3i_pkg::*;

   localparam int STEPS = E + 2;

   logic [NW-1:0] rem_ff  [STEPS];
   logic [DW-1:0] div_ff  [STEPS];
   logic [E:0]    quo_ff  [STEPS];
   logic          neg_ff  [STEPS];
   logic          dz_ff   [STEPS];
   logic          over_ff [STEPS];

   // First stage only checks whether the quotient would need more than E+1 bits.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         div_ff[0]  <= twod;
         quo_ff[0]  <= '0;
         neg_ff[0]  <= neg;
         dz_ff[0]   <= det_zero;
         over_ff[0] <= CW'(num) >= (CW'(twod) << (E+1));
      end
   end

   for (genvar j = 1; j < STEPS; j++) begin : g_step
      logic [CW-1:0] sub_in;
      logic          ge_in;

      always_comb begin
         sub_in = CW'(div_ff[j-1]) << (E+1-j);
         ge_in  = CW'(rem_ff[j-1]) >= sub_in;
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= ge_in ? NW'(CW'(rem_ff[j-1]) - sub_in) : rem_ff[j-1];
            div_ff[j]  <= div_ff[j-1];
            quo_ff[j]  <= {quo_ff[j-1][E-1:0], ge_in};
            neg_ff[j]  <= neg_ff[j-1];
            dz_ff[j]   <= dz_ff[j-1];
            over_ff[j] <= over_ff[j-1];
         end
      end
   end

   logic [E:0]          q;
   logic [E:0]          lim;
   logic                sat_pos;
   logic                sat_neg;
   logic signed [E-1:0] quot_in;
   logic                sat_in;
   logic signed [E-1:0] quot_ff;
   logic                sat_ff;

   always_comb begin
      q       = quo_ff[STEPS-1];
      lim     = (E+1)'(1) << (E-1);
      sat_pos = !neg_ff[STEPS-1] && (over_ff[STEPS-1] || q >= lim);
      sat_neg = neg_ff[STEPS-1] && (over_ff[STEPS-1] || q > lim);
      if (dz_ff[STEPS-1]) begin
         quot_in = '0;
      end else if (sat_pos) begin
         quot_in = $signed({1'b0, {(E-1){1'b1}}});
      end else if (sat_neg) begin
         quot_in = $signed({1'b1, {(E-1){1'b0}}});
      end else if (neg_ff[STEPS-1]) begin
         quot_in = $signed(E'(-q));
      end else begin
         quot_in = $signed(E'(q));
      end
      sat_in = !dz_ff[STEPS-1] && (sat_pos || sat_neg);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign quot = quot_ff;
   assign sat  = sat_ff;

endmodule

`default_nettype wire

// ===== hdl/matrix3x3_inverse_unit.sv =====
// Top level of the 3x3 matrix inverse unit: cofactor pipeline, nine dividers,
// valid tracking and stall control. Depends on mx3i_pkg, mx3i_cofactor, mx3i_divider.
`default_nettype none

// Inverts one signed fixed-point 3x3 matrix per clock while not stalled, by
// cofactors: the adjugate and determinant are exact, and each element is the
// adjugate entry divided by the determinant, rounded to nearest with ties away
// from zero and saturated to the element range. Throughput is one matrix per
// cycle while not stalled. The restoring dividers resolve one quotient bit per
// stage after seven cofactor and determinant stages. A stall on the result side
// while a result is valid freezes the whole pipeline and is passed back to the
// request side in the same cycle. A zero determinant returns all-zero elements
// with singular set.
module matrix3x3_inverse_unit #(
   parameter int ELEM_BITS = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [ELEM_BITS-1:0] req_a00,
   input  wire logic signed [ELEM_BITS-1:0] req_a01,
   input  wire logic signed [ELEM_BITS-1:0] req_a02,
   input  wire logic signed [ELEM_BITS-1:0] req_a10,
   input  wire logic signed [ELEM_BITS-1:0] req_a11,
   input  wire logic signed [ELEM_BITS-1:0] req_a12,
   input  wire logic signed [ELEM_BITS-1:0] req_a20,
   input  wire logic signed [ELEM_BITS-1:0] req_a21,
   input  wire logic signed [ELEM_BITS-1:0] req_a22,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [ELEM_BITS-1:0]      rsp_b00,
   output logic signed [ELEM_BITS-1:0]      rsp_b01,
   output logic signed [ELEM_BITS-1:0]      rsp_b02,
   output logic signed [ELEM_BITS-1:0]      rsp_b10,
   output logic signed [ELEM_BITS-1:0]      rsp_b11,
   output logic signed [ELEM_BITS-1:0]      rsp_b12,
   output logic signed [ELEM_BITS-1:0]      rsp_b20,
   output logic signed [ELEM_BITS-1:0]      rsp_b21,
   output logic signed [ELEM_BITS-1:0]      rsp_b22,
   output logic                             rsp_singular,
   output logic                             rsp_saturated
);
   import mx3i_pkg::*;

   localparam int E       = ELEM_BITS;
   localparam int F       = FRAC_BITS;
   localparam int AW      = 2*E + 1;
   localparam int DW      = 3*E + 1;
   localparam int MX      = (2*E + 2*F > 3*E) ? (2*E + 2*F) : (3*E);
   localparam int NW      = MX + 2;
   localparam int CW      = (NW > DW + E + 1) ? NW : (DW + E + 1);
   localparam int COF_LAT = 7;
   localparam int DIV_LAT = E + 3;
   localparam int LAT     = COF_LAT + DIV_LAT;

   logic                 en;
   logic signed [E-1:0]  elem [NUM_ELEMS];
   logic        [NW-1:0] num  [NUM_ELEMS];
   logic                 neg  [NUM_ELEMS];
   logic        [DW-1:0] twod;
   logic                 det_zero;
   logic signed [E-1:0]  quot [NUM_ELEMS];
   logic                 sat  [NUM_ELEMS];
   logic                 vld_ff  [LAT];
   logic                 sing_ff [DIV_LAT];

   // The pipeline moves unless a finished transaction is held at the output.
   assign en        = !(vld_ff[LAT-1] && rsp_stall);
   assign req_stall = !en;

   assign elem[0] = req_a00;
   assign elem[1] = req_a01;
   assign elem[2] = req_a02;
   assign elem[3] = req_a10;
   assign elem[4] = req_a11;
   assign elem[5] = req_a12;
   assign elem[6] = req_a20;
   assign elem[7] = req_a21;
   assign elem[8] = req_a22;

   mx3i_cofactor #(
      .E  (E),
      .F  (F),
      .AW (AW),
      .DW (DW),
      .NW (NW)
   ) u_cofactor (
      .clock    (clock),
      .en       (en),
      .elem     (elem),
      .num      (num),
      .neg      (neg),
      .twod     (twod),
      .det_zero (det_zero)
   );

   for (genvar k = 0; k < NUM_ELEMS; k++) begin : g_div
      mx3i_divider #(
         .E  (E),
         .NW (NW),
         .DW (DW),
         .CW (CW)
      ) u_divider (
         .clock    (clock),
         .en       (en),
         .num      (num[k]),
         .twod     (twod),
         .neg      (neg[k]),
         .det_zero (det_zero),
         .quot     (quot[k]),
         .sat      (sat[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < LAT; n++) begin
            vld_ff[n] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int n = 1; n < LAT; n++) begin
            vld_ff[n] <= vld_ff[n-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff[0] <= det_zero;
         for (int n = 1; n < DIV_LAT; n++) begin
            sing_ff[n] <= sing_ff[n-1];
         end
      end
   end

   assign rsp_valid     = vld_ff[LAT-1];
   assign rsp_b00       = quot[0];
   assign rsp_b01       = quot[1];
   assign rsp_b02       = quot[2];
   assign rsp_b10       = quot[3];
   assign rsp_b11       = quot[4];
   assign rsp_b12       = quot[5];
   assign rsp_b20       = quot[6];
   assign rsp_b21       = quot[7];
   assign rsp_b22       = quot[8];
   assign rsp_singular  = sing_ff[DIV_LAT-1];
   assign rsp_saturated = sat[0] | sat[1] | sat[2] | sat[3] | sat[4] |
                          sat[5] | sat[6] | sat[7] | sat[8];

endmodule

`default_nettype wire
